FILE: hdl/mebt_pkg.sv
package mebt_pkg;

	// Register and field widths
	localparam int OFS_W   = 48;
	localparam int ZOOM_W  = 47;
	localparam int SIZE_W  = 13;
	localparam int LIMIT_W = 16;
	localparam int CNT_W   = 16;

	// Working width of c and z
	localparam int Z_W = 64;

	// Coordinate multiplier: pixel or size times one half of zoom
	localparam int FMUL_A_W  = 16;
	localparam int ZOOM_LO_W = 24;
	localparam int FMUL_B_W  = 24;
	localparam int FMUL_P_W  = FMUL_A_W + FMUL_B_W;

	// Iteration multiplier: 32x32 partial products into a double-width sum
	localparam int MH_W  = 32;
	localparam int PP_W  = 2 * MH_W;
	localparam int ACC_W = 2 * Z_W;

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Register port
	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;
	localparam int REG_LSB = 3;

	// Saturation of the pixel term, +-2^61
	localparam logic signed [Z_W:0] T_LIM   = 65'sh0_2000_0000_0000_0000;
	localparam logic signed [Z_W:0] T_LIM_N = -T_LIM;

	// Reset values
	localparam logic [ZOOM_W-1:0]  ZOOM_RST   = 47'h10_0000_0000;
	localparam logic [SIZE_W-1:0]  WIDTH_RST  = 13'd1024;
	localparam logic [SIZE_W-1:0]  HEIGHT_RST = 13'd768;
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'd256;

	typedef enum logic [2:0] {
		REG_OFFSET_X = 3'd0,
		REG_OFFSET_Y = 3'd1,
		REG_ZOOM     = 3'd2,
		REG_WIDTH    = 3'd3,
		REG_HEIGHT   = 3'd4,
		REG_LIMIT    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] offset_x;
		logic signed [OFS_W-1:0] offset_y;
		logic [ZOOM_W-1:0]       zoom;
		logic [SIZE_W-1:0]       frame_w;
		logic [SIZE_W-1:0]       frame_h;
		logic [LIMIT_W-1:0]      iteration_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [Z_W-1:0] cr;
		logic signed [Z_W-1:0] ci;
	} coord_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_RUN,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_TEST,
		B_MUL
	} back_state_t;

endpackage

FILE: hdl/mebt_mul.sv
module mebt_mul #(
	parameter int SHIFT = 44
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [mebt_pkg::Z_W-1:0]      a,
	input  logic [mebt_pkg::Z_W-1:0]      b,
	input  logic                          neg,
	output logic                          rdy,
	output logic signed [mebt_pkg::Z_W-1:0] res
);
	import mebt_pkg::*;

	logic [Z_W-1:0]   a_q, b_q;
	logic             neg_q;
	logic             act_q;
	logic [1:0]       k_q;
	logic [PP_W-1:0]  pp_s1;
	logic [1:0]       sh_s1;
	logic             vld_s1, first_s1, last_s1;
	logic [ACC_W-1:0] acc_q;
	logic             fin_s2;
	logic             rdy_q;
	logic signed [Z_W-1:0] res_q;

	logic [MH_W-1:0]  a_half, b_half;
	logic [ACC_W-1:0] pp_ext, pp_shl;
	logic [ACC_W-1:0] quo;
	logic             rem;
	logic [Z_W-1:0]   mag;

	localparam logic [ACC_W-1:0] REM_MASK = (ACC_W'(1) << SHIFT) - ACC_W'(1);

	always_comb begin
		a_half = k_q[1] ? a_q[Z_W-1:MH_W] : a_q[MH_W-1:0];
		b_half = k_q[0] ? b_q[Z_W-1:MH_W] : b_q[MH_W-1:0];
		pp_ext = ACC_W'(pp_s1);
		case (sh_s1)
			2'd0:    pp_shl = pp_ext;
			2'd1:    pp_shl = pp_ext << MH_W;
			2'd2:    pp_shl = pp_ext << (2 * MH_W);
			default: pp_shl = '0;
		endcase
		quo = acc_q >> SHIFT;
		rem = |(acc_q & REM_MASK);
		mag = quo[Z_W-1:0] + Z_W'(rem & neg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			k_q    <= '0;
			vld_s1 <= 1'b0;
			fin_s2 <= 1'b0;
			rdy_q  <= 1'b0;
		end else begin
			if (go) begin
				act_q <= 1'b1;
				k_q   <= '0;
			end else if (act_q) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3)
					act_q <= 1'b0;
			end
			vld_s1 <= act_q;
			fin_s2 <= vld_s1 & last_s1;
			rdy_q  <= fin_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= a;
			b_q   <= b;
			neg_q <= neg;
		end
		pp_s1    <= PP_W'(a_half) * PP_W'(b_half);
		sh_s1    <= 2'(k_q[1]) + 2'(k_q[0]);
		first_s1 <= (k_q == 2'd0);
		last_s1  <= (k_q == 2'd3);
		if (vld_s1)
			acc_q <= first_s1 ? pp_shl : acc_q + pp_shl;
		// floor toward minus infinity: round the magnitude up when negative
		if (fin_s2)
			res_q <= neg_q ? -$signed(mag) : $signed(mag);
	end

	assign rdy = rdy_q;
	assign res = res_q;

endmodule

FILE: hdl/mebt_front.sv
module mebt_front #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COORD_WIDTH-1:0] pixel_x,
	input  logic [COORD_WIDTH-1:0] pixel_y,
	input  mebt_pkg::cfg_t         cfg,
	input  mebt_pkg::qstat_t       qstat,
	output logic                   busy,
	output logic                   push,
	output mebt_pkg::coord_t       push_data
);
	import mebt_pkg::*;

	localparam logic [2:0] SUB_T    = 3'd5;
	localparam logic [2:0] SUB_LAST = 3'd6;

	front_state_t state_q, state_d;
	logic         axis_q;
	logic [2:0]   sub_q;
	logic [COORD_WIDTH-1:0] px_q, py_q;
	logic [FMUL_P_W-1:0]    prod_s1;
	logic                   vld_s1, pos_s1, hi_s1;
	logic [Z_W-1:0]         pos_q, siz_q;
	logic signed [Z_W-1:0]  t_q, cr_q, ci_q;

	logic                   issue;
	logic [COORD_WIDTH-1:0] pix;
	logic [SIZE_W-1:0]      siz;
	logic [FMUL_A_W-1:0]    op_a;
	logic [FMUL_B_W-1:0]    op_b;
	logic [Z_W-1:0]         prod_shl;
	logic signed [Z_W:0]    diff;
	logic signed [Z_W-1:0]  t_sat;
	logic [OFS_W-1:0]       off;
	logic signed [Z_W-1:0]  c_val;

	always_comb begin
		pix   = axis_q ? py_q : px_q;
		siz   = axis_q ? cfg.frame_h : cfg.frame_w;
		op_a  = sub_q[1] ? FMUL_A_W'(siz) : FMUL_A_W'(pix);
		op_b  = sub_q[0] ? FMUL_B_W'(cfg.zoom[ZOOM_W-1:ZOOM_LO_W])
			: cfg.zoom[ZOOM_LO_W-1:0];
		issue = (state_q == F_RUN) && !sub_q[2];
		prod_shl = Z_W'(prod_s1) << ZOOM_LO_W;

		// pixel term minus half the image span, clamped
		diff = $signed({1'b0, pos_q}) - $signed({2'b00, siz_q[Z_W-1:1]});
		if (diff > T_LIM)
			t_sat = T_LIM[Z_W-1:0];
		else if (diff < T_LIM_N)
			t_sat = T_LIM_N[Z_W-1:0];
		else
			t_sat = diff[Z_W-1:0];

		off   = axis_q ? cfg.offset_y : cfg.offset_x;
		c_val = $signed({{(Z_W - OFS_W){off[OFS_W-1]}}, off}) + t_q;
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (start)
					state_d = F_RUN;
			end
			F_RUN: begin
				if (sub_q == SUB_LAST && axis_q)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				push = !qstat.full;
				if (!qstat.full)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			axis_q  <= 1'b0;
			sub_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (state_q == F_IDLE) begin
				axis_q <= 1'b0;
				sub_q  <= '0;
			end else if (state_q == F_RUN) begin
				if (sub_q == SUB_LAST) begin
					sub_q  <= '0;
					axis_q <= !axis_q;
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		prod_s1 <= FMUL_P_W'(op_a) * FMUL_P_W'(op_b);
		pos_s1  <= !sub_q[1];
		hi_s1   <= sub_q[0];
		if (vld_s1) begin
			if (pos_s1)
				pos_q <= hi_s1 ? pos_q + prod_shl : Z_W'(prod_s1);
			else
				siz_q <= hi_s1 ? siz_q + prod_shl : Z_W'(prod_s1);
		end
		if (state_q == F_RUN && sub_q == SUB_T)
			t_q <= t_sat;
		if (state_q == F_RUN && sub_q == SUB_LAST) begin
			if (axis_q)
				ci_q <= c_val;
			else
				cr_q <= c_val;
		end
	end

	assign busy      = (state_q != F_IDLE);
	assign push_data = '{cr: cr_q, ci: ci_q};

endmodule

FILE: hdl/mebt_queue.sv
module mebt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mebt_pkg::coord_t push_data,
	input  logic             pop,
	output mebt_pkg::coord_t pop_data,
	output mebt_pkg::qstat_t qstat
);
	import mebt_pkg::*;

	coord_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign pop_data    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + QPTR_W'(1);
			if (do_pop)
				rp_q <= rp_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= push_data;
	end

endmodule

FILE: hdl/mebt_back.sv
module mebt_back #(
	parameter int FRAC_BITS = 44
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [mebt_pkg::LIMIT_W-1:0]   iteration_limit,
	input  mebt_pkg::qstat_t               qstat,
	input  mebt_pkg::coord_t               qdata,
	output logic                           pop,
	output logic                           done,
	output logic [mebt_pkg::CNT_W-1:0]     escape_count
);
	import mebt_pkg::*;

	localparam logic signed [Z_W-1:0] TWO   = 64'sd2 <<< FRAC_BITS;
	localparam logic signed [Z_W-1:0] TWO_N = -TWO;
	localparam logic signed [Z_W-1:0] FOUR  = 64'sd4 <<< FRAC_BITS;

	back_state_t state_q, state_d;
	logic signed [Z_W-1:0] zr_q, zi_q, cr_q, ci_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;
	logic [CNT_W-1:0]      esc_q;

	logic                  big, stop, go, fin, step, rdy;
	logic                  rdy_re, rdy_im, rdy_x;
	logic [Z_W-1:0]        zr_mag, zi_mag;
	logic signed [Z_W-1:0] re2, im2, xprod;
	logic signed [Z_W:0]   sq_sum;
	logic                  escape;
	logic signed [Z_W-1:0] nzr, nzi;

	always_comb begin
		big = (zr_q >= TWO) || (zr_q <= TWO_N) || (zi_q >= TWO) || (zi_q <= TWO_N);
		stop   = (cnt_q >= iteration_limit) || big;
		zr_mag = zr_q[Z_W-1] ? Z_W'(-zr_q) : Z_W'(zr_q);
		zi_mag = zi_q[Z_W-1] ? Z_W'(-zi_q) : Z_W'(zi_q);
		rdy    = rdy_re & rdy_im & rdy_x;
		sq_sum = (Z_W+1)'(re2) + (Z_W+1)'(im2);
		escape = (sq_sum >= (Z_W+1)'(FOUR));
		nzr    = re2 - im2 + cr_q;
		nzi    = xprod + ci_q;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		go      = 1'b0;
		fin     = 1'b0;
		step    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = B_TEST;
				end
			end
			B_TEST: begin
				if (stop) begin
					fin     = 1'b1;
					state_d = B_IDLE;
				end else begin
					go      = 1'b1;
					state_d = B_MUL;
				end
			end
			B_MUL: begin
				if (rdy) begin
					if (escape) begin
						fin     = 1'b1;
						state_d = B_IDLE;
					end else begin
						step    = 1'b1;
						state_d = B_TEST;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cr_q  <= qdata.cr;
			ci_q  <= qdata.ci;
			zr_q  <= qdata.cr;
			zi_q  <= qdata.ci;
			cnt_q <= '0;
		end else if (step) begin
			zr_q  <= nzr;
			zi_q  <= nzi;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (fin)
			esc_q <= cnt_q;
	end

	mebt_mul #(.SHIFT(FRAC_BITS)) u_mul_re (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.a      (zr_mag),
		.b      (zr_mag),
		.neg    (1'b0),
		.rdy    (rdy_re),
		.res    (re2)
	);

	mebt_mul #(.SHIFT(FRAC_BITS)) u_mul_im (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.a      (zi_mag),
		.b      (zi_mag),
		.neg    (1'b0),
		.rdy    (rdy_im),
		.res    (im2)
	);

	mebt_mul #(.SHIFT(FRAC_BITS - 1)) u_mul_x (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.a      (zr_mag),
		.b      (zi_mag),
		.neg    (zr_q[Z_W-1] ^ zi_q[Z_W-1]),
		.rdy    (rdy_x),
		.res    (xprod)
	);

	assign done         = done_q;
	assign escape_count = esc_q;

endmodule

FILE: hdl/mandelbrot_escape_time_core.sv
// The front takes a new word only once the last is in the two-entry queue, stalling
// while full; the back iterates one point at a time on three 32x32 partial-product units.
// Reset: arst_n clears all control state and reloads the view registers to their defaults.
// done pulses for one cycle with escape_count; the receiver cannot stall it.
module mandelbrot_escape_time_core #(
	parameter int FRAC_BITS   = 44,
	parameter int COORD_WIDTH = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mebt_pkg::PADDR_W-1:0]   paddr,
	input  logic [mebt_pkg::PDATA_W-1:0]   pwdata,
	output logic [mebt_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,

	// pixel command
	input  logic                           start,
	output logic                           busy,
	input  logic [COORD_WIDTH-1:0]         pixel_x,
	input  logic [COORD_WIDTH-1:0]         pixel_y,

	// result word
	output logic                           done,
	output logic [mebt_pkg::CNT_W-1:0]     escape_count
);
	import mebt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     reg_wr;
	logic     push, pop;
	coord_t   push_data, pop_data;
	qstat_t   qstat;

	// Decode the register slot from the doubleword address; drop writes beyond the list.
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:REG_LSB]);
	assign reg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x        <= '0;
			cfg_q.offset_y        <= '0;
			cfg_q.zoom            <= ZOOM_RST;
			cfg_q.frame_w         <= WIDTH_RST;
			cfg_q.frame_h         <= HEIGHT_RST;
			cfg_q.iteration_limit <= LIMIT_RST;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_OFFSET_X: cfg_q.offset_x        <= pwdata[OFS_W-1:0];
				REG_OFFSET_Y: cfg_q.offset_y        <= pwdata[OFS_W-1:0];
				REG_ZOOM:     cfg_q.zoom            <= pwdata[ZOOM_W-1:0];
				REG_WIDTH:    cfg_q.frame_w         <= pwdata[SIZE_W-1:0];
				REG_HEIGHT:   cfg_q.frame_h         <= pwdata[SIZE_W-1:0];
				REG_LIMIT:    cfg_q.iteration_limit <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Return offsets sign-extended, the rest zero-extended.
	always_comb begin
		case (reg_idx)
			REG_OFFSET_X: prdata = PDATA_W'(cfg_q.offset_x);
			REG_OFFSET_Y: prdata = PDATA_W'(cfg_q.offset_y);
			REG_ZOOM:     prdata = PDATA_W'(cfg_q.zoom);
			REG_WIDTH:    prdata = PDATA_W'(cfg_q.frame_w);
			REG_HEIGHT:   prdata = PDATA_W'(cfg_q.frame_h);
			REG_LIMIT:    prdata = PDATA_W'(cfg_q.iteration_limit);
			default:      prdata = '0;
		endcase
	end

	// Front: take the pixel word and form c = offset + pixel*zoom - span/2 on a
	// shared 16x24 multiplier, one axis after the other, then hand it to the queue.
	mebt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	// Queue: hold finished points so the front can start the next pixel
	// while the back is still iterating.
	mebt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	// Back: iterate z = z^2 + c until the magnitude test fails or the limit
	// is reached, then pulse done with the count.
	mebt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.iteration_limit (cfg_q.iteration_limit),
		.qstat           (qstat),
		.qdata           (pop_data),
		.pop             (pop),
		.done            (done),
		.escape_count    (escape_count)
	);

endmodule

FILE: verif/tb_mandelbrot_escape_time_core.sv
module tb_mandelbrot_escape_time_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mebt_pkg::*;

	// Geometry of the instance under test, kept at the block defaults
	localparam int FRAC  = 44;
	localparam int PIX_W = 12;

	// One unit in Q20.44 and the escape radii on the component and on |z|^2
	localparam logic signed [63:0]  UNIT           = 64'sd1 <<< FRAC;
	localparam logic signed [127:0] MAG2           = 128'sd2 <<< FRAC;
	localparam logic signed [127:0] MAG4           = 128'sd4 <<< FRAC;
	localparam logic signed [127:0] PIXEL_TERM_CAP = 128'sd1 <<< 61;

	// Register slots beyond the mapped six; writes there must be dropped
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	// Run limits: a generous watchdog and the settle time after the last word
	localparam int CYCLE_LIMIT = 3000000;
	localparam int TAIL_CYCLES = 32;
	localparam int PRINT_CAP   = 40;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic [CNT_W-1:0] count;
	} pixel_expect_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 start;
	logic                 busy;
	logic [PIX_W-1:0]     pixel_x;
	logic [PIX_W-1:0]     pixel_y;
	logic                 done;
	logic [CNT_W-1:0]     escape_count;

	// Our own copy of the view registers, updated as each write lands
	logic signed [OFS_W-1:0] view_ofs_x;
	logic signed [OFS_W-1:0] view_ofs_y;
	logic [ZOOM_W-1:0]       view_zoom;
	logic [SIZE_W-1:0]       view_width;
	logic [SIZE_W-1:0]       view_height;
	logic [LIMIT_W-1:0]      view_limit;

	// Escape counts still owed by the block, oldest first
	pixel_expect_t escape_queue[$];
	pixel_expect_t oldest;
	pixel_expect_t fresh;

	int  cycles;
	int  mismatches;
	int  pixels_taken;
	int  counts_compared;
	int  cap_hits;
	int  escaped_at_once;
	int  reg_writes;
	bit  gaps_on;

	mandelbrot_escape_time_core #(
		.FRAC_BITS   (FRAC),
		.COORD_WIDTH (PIX_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.done         (done),
		.escape_count (escape_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Watchdog: give up if the block stops answering
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timed out after %0d cycles with %0d counts outstanding",
			cycles, escape_queue.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Map a pixel index to its coordinate on one axis: offset plus the pixel
	// term, the latter clamped to +-2^61 before the offset goes in. The half
	// span is floored, so odd and zero sizes fall out naturally.
	function automatic logic signed [127:0] pixel_point(
		input logic signed [OFS_W-1:0] ofs,
		input logic [PIX_W-1:0]        pix,
		input logic [SIZE_W-1:0]       size
	);
		logic [127:0]        pix_w;
		logic [127:0]        size_w;
		logic [127:0]        zoom_w;
		logic signed [127:0] pos;
		logic signed [127:0] half;
		logic signed [127:0] term;
		logic signed [127:0] base;
		pix_w  = 128'(pix);
		size_w = 128'(size);
		zoom_w = 128'(view_zoom);
		pos    = pix_w * zoom_w;
		half   = (size_w * zoom_w) >> 1;
		term   = pos - half;
		if (term > PIXEL_TERM_CAP)
			term = PIXEL_TERM_CAP;
		if (term < -PIXEL_TERM_CAP)
			term = -PIXEL_TERM_CAP;
		base = 128'(ofs);
		return base + term;
	endfunction

	// Iterate z = z^2 + c from z = c. Squares and the cross term are floored
	// toward minus infinity; 128-bit products keep them exact. A component
	// already at or past 2 stops the loop before any squaring.
	function automatic logic [CNT_W-1:0] predict_escape(
		input logic [PIX_W-1:0] px,
		input logic [PIX_W-1:0] py
	);
		logic signed [127:0] cr;
		logic signed [127:0] ci;
		logic signed [127:0] zr;
		logic signed [127:0] zi;
		logic signed [127:0] re2;
		logic signed [127:0] im2;
		logic signed [127:0] nzi;
		logic [16:0]         n;
		bit                  live;
		cr   = pixel_point(view_ofs_x, px, view_width);
		ci   = pixel_point(view_ofs_y, py, view_height);
		zr   = cr;
		zi   = ci;
		n    = '0;
		live = 1'b1;
		while (live && n < view_limit) begin
			if (zr >= MAG2 || zr <= -MAG2 || zi >= MAG2 || zi <= -MAG2) begin
				live = 1'b0;
			end else begin
				re2 = (zr * zr) >>> FRAC;
				im2 = (zi * zi) >>> FRAC;
				if (re2 + im2 >= MAG4) begin
					live = 1'b0;
				end else begin
					n   = n + 17'd1;
					nzi = ((zr * zi) >>> (FRAC - 1)) + ci;
					zr  = re2 - im2 + cr;
					zi  = nzi;
				end
			end
		end
		return n[CNT_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	// Compare each done word with the oldest owed count, then log any pixel
	// taken at this edge. Both happen in the one block so the queue order
	// never depends on scheduling.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (escape_queue.size() == 0) begin
					report_mismatch($sformatf("escape_count %0d with no pixel outstanding",
						escape_count));
				end else begin
					oldest = escape_queue.pop_front();
					counts_compared++;
					if (escape_count !== oldest.count)
						report_mismatch($sformatf("pixel (%0d,%0d): escape_count %0d, want %0d",
							oldest.x, oldest.y, escape_count, oldest.count));
				end
			end
			if (start && !busy) begin
				fresh.x     = pixel_x;
				fresh.y     = pixel_y;
				fresh.count = predict_escape(pixel_x, pixel_y);
				if (fresh.count == view_limit)
					cap_hits++;
				if (fresh.count == '0)
					escaped_at_once++;
				pixels_taken++;
				escape_queue.push_back(fresh);
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one pixel and hold it until the block takes it. start is left
	// high on return so back-to-back pixels need no second assignment in the
	// same step; it is dropped only for a gap or when the stream pauses.
	task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		if (gaps_on && $urandom_range(99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		start   <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait for every owed count, then a short tail so that a
	// stray done pulse would still be caught before anything else changes.
	task automatic settle_idle();
		start <= 1'b0;
		@(posedge clk);
		while (escape_queue.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Setup, access, then idle with psel low, so the next transfer
	// never reassigns psel in the step this one finishes.
	task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
		logic [PADDR_W-1:0] addr;
		addr = PADDR_W'(idx);
		addr = addr << REG_LSB;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_OFFSET_X: view_ofs_x  = value[OFS_W-1:0];
			REG_OFFSET_Y: view_ofs_y  = value[OFS_W-1:0];
			REG_ZOOM:     view_zoom   = value[ZOOM_W-1:0];
			REG_WIDTH:    view_width  = value[SIZE_W-1:0];
			REG_HEIGHT:   view_height = value[SIZE_W-1:0];
			REG_LIMIT:    view_limit  = value[LIMIT_W-1:0];
			default:      ;
		endcase
		reg_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_reg(input logic [2:0] idx, output logic [PDATA_W-1:0] value);
		logic [PADDR_W-1:0] addr;
		addr = PADDR_W'(idx);
		addr = addr << REG_LSB;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Register contents as stored, zero-extended, and the bits that matter;
	// bits above a register's width are not compared.
	function automatic logic [PDATA_W-1:0] reg_image(input logic [2:0] idx);
		case (idx)
			REG_OFFSET_X: return {16'd0, view_ofs_x};
			REG_OFFSET_Y: return {16'd0, view_ofs_y};
			REG_ZOOM:     return {17'd0, view_zoom};
			REG_WIDTH:    return {51'd0, view_width};
			REG_HEIGHT:   return {51'd0, view_height};
			REG_LIMIT:    return {48'd0, view_limit};
			default:      return '0;
		endcase
	endfunction

	function automatic logic [PDATA_W-1:0] reg_mask(input logic [2:0] idx);
		case (idx)
			REG_OFFSET_X, REG_OFFSET_Y: return {16'd0, {OFS_W{1'b1}}};
			REG_ZOOM:                   return {17'd0, {ZOOM_W{1'b1}}};
			REG_WIDTH, REG_HEIGHT:      return {51'd0, {SIZE_W{1'b1}}};
			REG_LIMIT:                  return {48'd0, {LIMIT_W{1'b1}}};
			default:                    return '0;
		endcase
	endfunction

	task automatic check_registers();
		logic [PDATA_W-1:0] got;
		logic [2:0]         idx;
		for (int i = REG_OFFSET_X; i <= REG_LIMIT; i++) begin
			idx = 3'(i);
			read_reg(idx, got);
			if ((got & reg_mask(idx)) !== reg_image(idx))
				report_mismatch($sformatf("register %0d reads %h, holds %h",
					i, got & reg_mask(idx), reg_image(idx)));
		end
	endtask

	// Load a whole view; the block must be idle first
	task automatic set_view(
		input logic signed [63:0] ox,
		input logic signed [63:0] oy,
		input logic [63:0]        z,
		input logic [63:0]        w,
		input logic [63:0]        h,
		input logic [63:0]        lim
	);
		settle_idle();
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_ZOOM, z);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_LIMIT, lim);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset view: 1024x768 around the origin, pixel pitch 1/256, cap 256.
	// Corner (0,0) sits at (-2,-1.5) and is stopped by the component test;
	// the centre and (-1,0) never escape and run to the cap.
	task automatic test_reset_view();
		check_registers();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd512, 12'd384);
		send_pixel(12'd256, 12'd384);
		send_pixel(12'd600, 12'd384);
		send_pixel(12'd1023, 12'd767);
	endtask

	// Both extremes of every register, with junk in the unused upper bits,
	// read back; then writes to the spare slots must change nothing.
	task automatic test_register_port();
		settle_idle();
		write_reg(REG_OFFSET_X, 64'h0000_7FFF_FFFF_FFFF);
		write_reg(REG_OFFSET_Y, 64'hFFFF_8000_0000_0000);
		write_reg(REG_ZOOM, '1);
		write_reg(REG_WIDTH, '1);
		write_reg(REG_HEIGHT, 64'hFFFF_FFFF_FFFF_E000);
		write_reg(REG_LIMIT, '1);
		check_registers();
		write_reg(REG_OFFSET_X, 64'h5A5A_8000_0000_0000);
		write_reg(REG_OFFSET_Y, 64'hA5A5_7FFF_FFFF_FFFF);
		write_reg(REG_ZOOM, 64'hFFFF_8000_0000_0000);
		write_reg(REG_WIDTH, 64'hFFFF_FFFF_FFFF_E000);
		write_reg(REG_HEIGHT, '1);
		write_reg(REG_LIMIT, 64'hFFFF_FFFF_FFFF_0000);
		check_registers();
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, '1);
		check_registers();
	endtask

	task automatic test_view_edges();
		// Zoom zero pins c to the offset whatever the pixel
		set_view(0, 0, 0, 1024, 768, 20);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		// Offsets at their extremes sit far outside radius two
		set_view(64'sh0000_7FFF_FFFF_FFFF, 64'shFFFF_8000_0000_0000, 0, 1024, 768, 20);
		send_pixel(12'd0, 12'd0);
		// Widest pixel term the registers allow, against a zero height
		set_view(0, 0, 64'h0000_7FFF_FFFF_FFFF, 8191, 0, 20);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		// Zero sizes: no centring, pixel (0,0) is the origin
		set_view(0, 0, UNIT >>> 3, 0, 0, 20);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd3, 12'd2);
		// Odd sizes with an odd zoom, so the half span must be floored
		set_view(0, 0, (UNIT >>> 1) + 1, 3, 1, 20);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd2, 12'd0);
		// Just inside radius two on the imaginary axis: one pass, then out
		set_view(0, 2 * UNIT - 1, 0, 1, 1, 20);
		send_pixel(12'd0, 12'd0);
		set_view(0, -2 * UNIT + 1, 0, 1, 1, 20);
		send_pixel(12'd0, 12'd0);
		// Both components below two but |c|^2 = 4.5: the square test stops it
		set_view(3 * (UNIT >>> 1), 3 * (UNIT >>> 1), 0, 1, 1, 20);
		send_pixel(12'd0, 12'd0);
	endtask

	task automatic test_zero_limit();
		set_view(0, 0, 64'd68719476736, 1024, 768, 0);
		send_pixel(12'd512, 12'd384);
		send_pixel(12'd4095, 12'd4095);
	endtask

	// Top of the cap range with pixels that escape quickly, then one point
	// of the set that runs a long cap out
	task automatic test_long_limit();
		set_view(0, 0, 64'd68719476736, 1024, 768, 65535);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1023, 12'd767);
		send_pixel(12'd600, 12'd384);
		set_view(0, 0, 64'd68719476736, 1024, 768, 4000);
		send_pixel(12'd512, 12'd384);
	endtask

	// A view that frames the set: width times zoom spans three units, centred
	// near -0.75 with some jitter. Zoomed-in views shrink the pitch so most
	// pixels land on the boundary and run long.
	task automatic load_random_view(input bit zoom_in);
		logic [12:0]        w;
		logic [12:0]        h;
		logic [63:0]        z;
		logic signed [63:0] ox;
		logic signed [63:0] oy;
		w  = 13'($urandom_range(1, 4096));
		h  = 13'($urandom_range(1, 4096));
		z  = (64'd3 << FRAC) / w;
		ox = {32'd0, $urandom};
		ox = (ox <<< 10) - (64'sd1 <<< 41) - (64'sd3 <<< (FRAC - 2));
		oy = {32'd0, $urandom};
		oy = (oy <<< 9) - (64'sd1 <<< 40);
		if (zoom_in) begin
			z = z >> $urandom_range(2, 14);
			set_view(ox, oy, z, 64'(w), 64'(h), 64'($urandom_range(200, 300)));
		end else begin
			set_view(ox, oy, z, 64'(w), 64'(h), 64'($urandom_range(0, 48)));
		end
	endtask

	// Any register contents at all, junk above the register widths included;
	// the cap is kept low so a stray point of the set stays cheap.
	task automatic load_wild_view();
		logic [63:0] lim;
		lim       = {$urandom, $urandom};
		lim[15:0] = 16'($urandom_range(0, 64));
		set_view({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, lim);
	endtask

	task automatic test_random_views();
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		bit               wild;
		for (int phase = 0; phase < 10; phase++) begin
			wild = (phase == 7 || phase == 8);
			if (wild)
				load_wild_view();
			else
				load_random_view(phase == 6);
			// Last phase runs with no gaps at all
			gaps_on = (phase != 9);
			for (int k = 0; k < 48; k++) begin
				// Pause mid-phase on odd phases until every count is back
				if (k == 24 && phase % 2 == 1)
					settle_idle();
				if (!wild && $urandom_range(99) < 85) begin
					x = PIX_W'($urandom_range(0, view_width - 1));
					y = PIX_W'($urandom_range(0, view_height - 1));
				end else begin
					x = PIX_W'($urandom_range(0, 4095));
					y = PIX_W'($urandom_range(0, 4095));
				end
				send_pixel(x, y);
			end
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		start   <= 1'b0;
		pixel_x <= '0;
		pixel_y <= '0;
		cycles          = 0;
		mismatches      = 0;
		pixels_taken    = 0;
		counts_compared = 0;
		cap_hits        = 0;
		escaped_at_once = 0;
		reg_writes      = 0;
		gaps_on         = 1'b1;
		// Register values the block comes out of reset with
		view_ofs_x  = '0;
		view_ofs_y  = '0;
		view_zoom   = 47'd68719476736;
		view_width  = 13'd1024;
		view_height = 13'd768;
		view_limit  = 16'd256;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_view();
		test_register_port();
		test_view_edges();
		test_zero_limit();
		test_long_limit();
		test_random_views();

		settle_idle();
		if (escape_queue.size() != 0)
			report_mismatch($sformatf("%0d escape counts never arrived", escape_queue.size()));
		$display("%0d pixels over %0d register writes; %0d counts compared",
			pixels_taken, reg_writes, counts_compared);
		$display("%0d pixels ran to the cap, %0d escaped before any pass; %0d mismatches",
			cap_hits, escaped_at_once, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
hdl/mebt_pkg.sv
hdl/mebt_mul.sv
hdl/mebt_front.sv
hdl/mebt_queue.sv
hdl/mebt_back.sv
hdl/mandelbrot_escape_time_core.sv
verif/tb_mandelbrot_escape_time_core.sv
